// ----- sv/pdmpl_pkg.sv -----
// ---------------------------------------------------------------------------
// PD motor position loop package
// Shared types, register indexes, reset values and sizes for the PD loop.
// ---------------------------------------------------------------------------
package pdmpl_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_cfg_idx CFG_KP_GAIN      = 2'd0;
    localparam t_cfg_idx CFG_KD_RATE      = 2'd1;
    localparam t_cfg_idx CFG_ENCODER_SPAN = 2'd2;
    localparam t_cfg_idx CFG_SPEED_LIMIT  = 2'd3;

    localparam logic [15:0] KP_GAIN_RST      = 16'd1024;
    localparam logic [15:0] KD_RATE_RST      = 16'd3;
    localparam logic [14:0] ENCODER_SPAN_RST = 15'd8192;
    localparam logic [7:0]  SPEED_LIMIT_RST  = 8'd150;

    // Magnitude of encoder_position * 255 fits in 23 bits.
    localparam int DIV_STEPS = 23;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic signed [15:0] encoder_position;
        logic        [7:0]  position_reference;
    } t_in_item;

    typedef struct packed {
        logic       direction_right;
        logic [7:0] speed;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_step;
        logic calc_err;
        logic mul_p;
        logic mul_d;
        logic out_load;
    } t_cmd;

endpackage

// ----- sv/pdmpl_ctrl.sv -----
// ---------------------------------------------------------------------------
// PD loop controller
// Sequences one request through divide, error, two multiplies and output.
// ---------------------------------------------------------------------------
module pdmpl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output pdmpl_pkg::t_cmd  o_cmd
);
    import pdmpl_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_ERR  = 6'b000100,
        S_MULP = 6'b001000,
        S_MULD = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state               r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;
    logic                 w_out_free;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_ERR;
                end
            end
            S_ERR: begin
                o_cmd.calc_err = 1'b1;
                n_state        = S_MULP;
            end
            S_MULP: begin
                o_cmd.mul_p = 1'b1;
                n_state     = S_MULD;
            end
            S_MULD: begin
                o_cmd.mul_d = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- sv/pdmpl_dp.sv -----
// ---------------------------------------------------------------------------
// PD loop datapath
// Configuration registers, serial divider, shared multiplier and output stage.
// ---------------------------------------------------------------------------
module pdmpl_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  pdmpl_pkg::t_cfg_idx   i_cfg_index,
    input  pdmpl_pkg::t_cfg_data  i_cfg_data,
    input  pdmpl_pkg::t_in_item   i_in_data,
    input  pdmpl_pkg::t_cmd       i_cmd,
    output pdmpl_pkg::t_out_item  o_out_data
);
    import pdmpl_pkg::*;

    // Configuration registers.
    logic [15:0] r_kp_gain;
    logic [15:0] r_kd_rate;
    logic [14:0] r_span;
    logic [7:0]  r_speed_limit;

    // Work registers.
    logic [15:0]           r_rem;
    logic [DIV_STEPS-1:0]  r_quo;
    logic                  r_neg;
    logic                  r_pos_pos;
    logic                  r_pos_neg;
    logic [7:0]            r_ref;
    logic signed [16:0]    r_err;
    logic signed [17:0]    r_diff;
    logic signed [16:0]    r_last_err;
    logic                  r_right;
    logic signed [35:0]    r_acc;
    t_out_item             r_out;

    logic signed [24:0] w_prod;
    logic [24:0]        w_prod_mag;
    logic [16:0]        w_trial;
    logic [15:0]        w_shift;
    logic signed [15:0] w_scaled;
    logic signed [16:0] w_err;
    logic signed [17:0] w_diff;
    logic signed [16:0] w_mul_a;
    logic signed [17:0] w_mul_b;
    logic signed [34:0] w_mul_p;
    logic signed [35:0] w_act_adj;
    logic signed [27:0] w_act;
    logic signed [28:0] w_sel;
    logic [7:0]         w_speed;

    // encoder_position * 255 as a shift and subtract.
    assign w_prod = $signed({i_in_data.encoder_position[15], i_in_data.encoder_position, 8'h00})
                  - $signed({{9{i_in_data.encoder_position[15]}}, i_in_data.encoder_position});
    assign w_prod_mag = w_prod[24] ? (25'd0 - w_prod) : w_prod;

    // One restoring division step per cycle; the dividend shifts out of r_quo.
    assign w_shift = {r_rem[14:0], r_quo[DIV_STEPS-1]};
    assign w_trial = {1'b0, w_shift} - {2'b00, r_span};

    always_comb begin
        if (r_span == '0) begin
            // A zero span acts as an infinitely steep scale.
            if (r_pos_pos) begin
                w_scaled = 16'sh7FFF;
            end else if (r_pos_neg) begin
                w_scaled = 16'sh8000;
            end else begin
                w_scaled = '0;
            end
        end else if (r_neg) begin
            if (r_quo > DIV_STEPS'(32768)) begin
                w_scaled = 16'sh8000;
            end else begin
                w_scaled = $signed(16'd0 - r_quo[15:0]);
            end
        end else begin
            if (r_quo > DIV_STEPS'(32767)) begin
                w_scaled = 16'sh7FFF;
            end else begin
                w_scaled = $signed(r_quo[15:0]);
            end
        end
    end

    assign w_err  = $signed({9'd0, r_ref}) - $signed({w_scaled[15], w_scaled});
    assign w_diff = $signed({w_err[16], w_err}) - $signed({r_last_err[16], r_last_err});

    // Shared multiplier: kp * error, then kd_rate * error difference.
    assign w_mul_a = i_cmd.mul_p ? $signed({1'b0, r_kp_gain}) : $signed({1'b0, r_kd_rate});
    assign w_mul_b = i_cmd.mul_p ? $signed({r_err[16], r_err}) : r_diff;
    assign w_mul_p = w_mul_a * w_mul_b;

    // Divide by 256 with truncation toward zero.
    assign w_act_adj = r_acc + (r_acc[35] ? 36'sd255 : 36'sd0);
    assign w_act     = w_act_adj[35:8];
    assign w_sel     = r_right ? $signed({w_act[27], w_act}) : -$signed({w_act[27], w_act});

    always_comb begin
        if (w_sel[28]) begin
            w_speed = '0;
        end else if (w_sel[27:0] > {20'd0, r_speed_limit}) begin
            w_speed = r_speed_limit;
        end else begin
            w_speed = w_sel[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp_gain     <= KP_GAIN_RST;
            r_kd_rate     <= KD_RATE_RST;
            r_span        <= ENCODER_SPAN_RST;
            r_speed_limit <= SPEED_LIMIT_RST;
            r_last_err    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_KP_GAIN:      r_kp_gain     <= i_cfg_data;
                    CFG_KD_RATE:      r_kd_rate     <= i_cfg_data;
                    CFG_ENCODER_SPAN: r_span        <= i_cfg_data[14:0];
                    CFG_SPEED_LIMIT:  r_speed_limit <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_cmd.calc_err) begin
                r_last_err <= w_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem     <= '0;
            r_quo     <= w_prod_mag[DIV_STEPS-1:0];
            r_neg     <= w_prod[24];
            r_pos_pos <= !i_in_data.encoder_position[15] && (i_in_data.encoder_position != '0);
            r_pos_neg <= i_in_data.encoder_position[15];
            r_ref     <= i_in_data.position_reference;
        end
        if (i_cmd.div_step) begin
            r_rem <= w_trial[16] ? w_shift : w_trial[15:0];
            r_quo <= {r_quo[DIV_STEPS-2:0], !w_trial[16]};
        end
        if (i_cmd.calc_err) begin
            r_err   <= w_err;
            r_diff  <= w_diff;
            r_right <= (w_err > 17'sd0);
        end
        if (i_cmd.mul_p) begin
            r_acc <= 36'(w_mul_p);
        end
        if (i_cmd.mul_d) begin
            r_acc <= r_acc + 36'(w_mul_p);
        end
        if (i_cmd.out_load) begin
            r_out.direction_right <= r_right;
            r_out.speed           <= w_speed;
        end
    end

    assign o_out_data = r_out;

endmodule

// ----- sv/pd_motor_position_loop_core.sv -----
// ---------------------------------------------------------------------------
// PD motor position loop core
// Scales an encoder reading by 255/span, forms the PD actuation and outputs
// a direction and a speed clamped to the configured speed limit.
//
//   channel | valid        | stall        | payload
//   --------+--------------+--------------+---------------------------
//   input   | i_in_valid   | o_in_stall   | i_in_data  (t_in_item)
//   output  | o_out_valid  | i_out_stall  | o_out_data (t_out_item)
//   config  | i_cfg_we     | none         | i_cfg_index, i_cfg_data
//
// A request is accepted in the idle state and then passes through the serial
// divider, the error step, the kp and kd multiplies on the shared multiplier
// and the output load; the next request is accepted only back in idle.
// The output register holds a result while the next request is worked on;
// the final load waits for the previous result to be taken.
// Synchronous active-low reset restores the register defaults and clears
// the stored last error.
// ---------------------------------------------------------------------------
module pd_motor_position_loop_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  pdmpl_pkg::t_cfg_idx   i_cfg_index,
    input  pdmpl_pkg::t_cfg_data  i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  pdmpl_pkg::t_in_item   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output pdmpl_pkg::t_out_item  o_out_data
);
    import pdmpl_pkg::*;

    t_cmd w_cmd;

    pdmpl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    pdmpl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- sv/pdmpl_checker.sv -----
// ---------------------------------------------------------------------------
// PD loop port checker
// Watches the core's ports for handshake and sequencing rules.
// ---------------------------------------------------------------------------
module pdmpl_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input pdmpl_pkg::t_out_item  o_out_data
);
    import pdmpl_pkg::*;

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result does not change.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("result changed while stalled");

    // The core works on one request at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request accepted while busy");

    // A result does not appear straight after an acceptance.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> ##1 !$rose(o_out_valid))
        else $error("result appeared too early");

    // Reset leaves the core idle with no result.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("core not idle after reset");

endmodule

bind pd_motor_position_loop_core pdmpl_checker u_pdmpl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ----- dv/testbench.sv -----
// ---------------------------------------------------------------------------
// PD motor position loop core testbench
// Drives encoder requests through the valid/stall channels, predicts every
// direction and speed with its own fixed-point model of the PD loop, and
// checks the results in order under random idling and back-pressure.
// ---------------------------------------------------------------------------
module testbench;
    import pdmpl_pkg::*;

    localparam int SETTLE_CYCLES    = 40;
    localparam int TAIL_CYCLES      = 40;
    localparam int RAND_PHASES      = 8;
    localparam int RAND_PER_PHASE   = 185;
    localparam int LONG_HOLD_AT     = 120;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int REPORT_LIMIT     = 10;

    class pd_loop_scoreboard;
        logic [15:0]        kp_gain;
        logic [15:0]        kd_rate;
        logic [14:0]        span;
        logic [7:0]         speed_limit;
        logic signed [16:0] last_error;
        t_out_item          expected_moves[$];
        int                 n_req;
        int                 n_moves;
        int                 n_bad;
        int                 n_clamped;
        int                 n_opposed;

        function new();
            kp_gain     = KP_GAIN_RST;
            kd_rate     = KD_RATE_RST;
            span        = ENCODER_SPAN_RST;
            speed_limit = SPEED_LIMIT_RST;
            last_error  = '0;
        endfunction

        function void write_reg(t_cfg_idx idx, t_cfg_data data);
            case (idx)
                CFG_KP_GAIN:      kp_gain = data;
                CFG_KD_RATE:      kd_rate = data;
                CFG_ENCODER_SPAN: span = data[14:0];
                CFG_SPEED_LIMIT:  speed_limit = data[7:0];
                default: ;
            endcase
        endfunction

        // Works out the move for one accepted request and advances last_error.
        function void note_request(t_in_item req);
            int        pos;
            int        pos_ref;
            int        span_i;
            int        scaled;
            int        err;
            longint    diff;
            longint    sum;
            longint    act;
            longint    mag;
            longint    kp_l;
            longint    kd_l;
            longint    max_l;
            t_out_item move;
            pos     = $signed(req.encoder_position);
            pos_ref = int'(req.position_reference);
            span_i  = int'(span);
            kp_l    = longint'(kp_gain);
            kd_l    = longint'(kd_rate);
            max_l   = longint'(speed_limit);
            // A zero span acts as an infinitely steep scale.
            if (span_i == 0) begin
                scaled = (pos > 0) ? 32767 : ((pos < 0) ? -32768 : 0);
            end else begin
                scaled = (pos * 255) / span_i;
                if (scaled > 32767) scaled = 32767;
                if (scaled < -32768) scaled = -32768;
            end
            err  = pos_ref - scaled;
            diff = longint'(err) - longint'(last_error);
            sum  = kp_l * longint'(err) + kd_l * diff;
            act  = sum / 256;
            move.direction_right = (err > 0);
            mag = move.direction_right ? act : -act;
            if (mag < 0) begin
                mag = 0;
                n_opposed++;
            end
            if (mag > max_l) begin
                mag = max_l;
                n_clamped++;
            end
            move.speed = mag[7:0];
            last_error = err[16:0];
            expected_moves.push_back(move);
            n_req++;
        endfunction

        function void check_move(t_out_item got);
            t_out_item want;
            n_moves++;
            if (expected_moves.size() == 0) begin
                n_bad++;
                if (n_bad <= REPORT_LIMIT)
                    $display("tb: result %0d arrived with no request pending: dir %0b speed %0d",
                             n_moves, got.direction_right, got.speed);
            end else begin
                want = expected_moves.pop_front();
                if (got.direction_right !== want.direction_right || got.speed !== want.speed) begin
                    n_bad++;
                    if (n_bad <= REPORT_LIMIT)
                        $display("tb: result %0d expected dir %0b speed %0d, got dir %0b speed %0d",
                                 n_moves, want.direction_right, want.speed,
                                 got.direction_right, got.speed);
                end
            end
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cfg_we    = 1'b0;
    t_cfg_idx  cfg_index = '0;
    t_cfg_data cfg_data  = '0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    pd_loop_scoreboard sb = new();
    t_in_item plan[$];
    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    int  stall_left  = 0;
    bit  held_long   = 1'b0;
    int  cur_span    = int'(ENCODER_SPAN_RST);
    int  walk_pos    = 0;
    int  walk_ref    = 128;
    int  n_settings  = 1;

    always #5 clk = ~clk;

    pd_motor_position_loop_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    function automatic void add_req(logic signed [15:0] pos, logic [7:0] pos_ref);
        t_in_item req;
        req.encoder_position   = pos;
        req.position_reference = pos_ref;
        plan.push_back(req);
    endfunction

    // Mostly a motor wandering within its span under a held setpoint,
    // the rest raw noise and end-of-range readings.
    function automatic t_in_item make_request();
        t_in_item req;
        int       kind;
        int       delta;
        int       tmp;
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
            if ($urandom_range(0, 19) == 0) walk_ref = $urandom_range(0, 255);
            if (cur_span == 0) begin
                walk_pos = int'($urandom_range(0, 200)) - 100;
            end else begin
                delta = $urandom_range(0, cur_span / 8 + 1);
                if ($urandom_range(0, 1) == 1) walk_pos += delta;
                else walk_pos -= delta;
                if (walk_pos < 0) walk_pos = 0;
                if (walk_pos > cur_span) walk_pos = cur_span;
            end
            req.encoder_position   = walk_pos[15:0];
            req.position_reference = walk_ref[7:0];
        end else if (kind < 8) begin
            req.encoder_position   = 16'($urandom_range(0, 65535));
            req.position_reference = 8'($urandom_range(0, 255));
        end else begin
            case ($urandom_range(0, 5))
                0: tmp = -32768;
                1: tmp = 32767;
                2: tmp = 0;
                3: tmp = -1;
                4: tmp = cur_span;
                default: tmp = -cur_span;
            endcase
            req.encoder_position = tmp[15:0];
            case ($urandom_range(0, 2))
                0: req.position_reference = 8'd0;
                1: req.position_reference = 8'd255;
                default: req.position_reference = 8'($urandom_range(0, 255));
            endcase
        end
        return req;
    endfunction

    task automatic send_req(t_in_item req);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_request(req);
    endtask

    task automatic send_plan();
        while (plan.size() > 0) send_req(plan.pop_front());
        in_valid <= 1'b0;
    endtask

    task automatic write_reg(t_cfg_idx idx, t_cfg_data data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    // Registers only change once every pending request has come back.
    task automatic program_regs(t_cfg_data kp, t_cfg_data kd, t_cfg_data span,
                                t_cfg_data max_spd);
        while (sb.expected_moves.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_KP_GAIN, kp);
        write_reg(CFG_KD_RATE, kd);
        write_reg(CFG_ENCODER_SPAN, span);
        write_reg(CFG_SPEED_LIMIT, max_spd);
        cfg_we   <= 1'b0;
        cur_span = int'(span[14:0]);
        walk_pos = (cur_span == 0) ? 0 : $urandom_range(0, cur_span);
        n_settings++;
    endtask

    initial begin : rx_side
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) sb.check_move(out_data);
            // One long hold lets the core fill up and push back on requests.
            if (!held_long && sb.n_moves >= LONG_HOLD_AT) begin
                held_long  = 1'b1;
                stall_left = LONG_HOLD_CYCLES;
            end else if (stall_left == 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                stall_left = $urandom_range(1, 12);
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        t_cfg_data kp_v;
        t_cfg_data kd_v;
        t_cfg_data span_v;
        t_cfg_data max_v;
        int        ph;
        int        i;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 25;
        rx_idle_pct = 25;
        add_req(16'sd0, 8'd0);
        add_req(16'sd0, 8'd255);
        add_req(16'sd8192, 8'd255);
        add_req(16'sd32767, 8'd0);
        add_req(-16'sd32768, 8'd255);
        add_req(-16'sd1, 8'd0);
        add_req(16'sd1, 8'd1);
        add_req(16'sd4096, 8'd127);
        add_req(16'sd4112, 8'd128);
        add_req(16'sd8191, 8'd0);
        add_req(16'sd16384, 8'd255);
        add_req(-16'sd8192, 8'd0);
        send_plan();

        // Unit span saturates the scaled position; a big derivative term
        // drives both the opposed-actuation and the clamp cases.
        program_regs(16'd0, 16'hFFFF, 16'd1, 16'd255);
        add_req(16'sd32767, 8'd0);
        add_req(-16'sd32768, 8'd255);
        add_req(-16'sd32768, 8'd255);
        add_req(16'sd0, 8'd100);
        add_req(16'sd0, 8'd0);
        add_req(16'sd1, 8'd0);
        send_plan();

        program_regs(16'hFFFF, 16'd0, 16'd0, 16'd0);
        add_req(16'sd5, 8'd10);
        add_req(-16'sd5, 8'd10);
        add_req(16'sd0, 8'd10);
        add_req(16'sd0, 8'd0);
        add_req(16'sd32767, 8'd255);
        send_plan();

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            case ($urandom_range(0, 4))
                0: kp_v = 16'd0;
                1: kp_v = 16'hFFFF;
                2: kp_v = 16'($urandom_range(0, 65535));
                default: kp_v = 16'($urandom_range(64, 4096));
            endcase
            case ($urandom_range(0, 4))
                0: kd_v = 16'd0;
                1: kd_v = 16'hFFFF;
                2: kd_v = 16'($urandom_range(0, 65535));
                default: kd_v = 16'($urandom_range(0, 2048));
            endcase
            case ($urandom_range(0, 9))
                0: span_v = 16'd0;
                1: span_v = 16'd1;
                2: span_v = 16'h7FFF;
                3, 4, 5: span_v = 16'($urandom_range(1, 32767));
                default: span_v = 16'($urandom_range(64, 8192));
            endcase
            if (ph == 0) span_v = 16'h7FFF;
            case ($urandom_range(0, 3))
                0: max_v = 16'd0;
                1: max_v = 16'd255;
                default: max_v = 16'($urandom_range(0, 255));
            endcase
            program_regs(kp_v, kd_v, span_v, max_v);

            if (ph == RAND_PHASES - 1) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else begin
                case ($urandom_range(0, 3))
                    0: tx_idle_pct = 0;
                    1: tx_idle_pct = 10;
                    2: tx_idle_pct = 30;
                    default: tx_idle_pct = 60;
                endcase
                case ($urandom_range(0, 3))
                    0: rx_idle_pct = 0;
                    1: rx_idle_pct = 10;
                    2: rx_idle_pct = 30;
                    default: rx_idle_pct = 60;
                endcase
            end
            walk_ref = $urandom_range(0, 255);
            for (i = 0; i < RAND_PER_PHASE; i++) plan.push_back(make_request());
            send_plan();
        end

        while (sb.expected_moves.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("tb: %0d requests checked under %0d register settings", sb.n_req, n_settings);
        $display("tb: %0d speeds held at the speed limit, %0d opposed actuations zeroed",
                 sb.n_clamped, sb.n_opposed);
        if (sb.expected_moves.size() != 0)
            $display("tb: %0d expected results never arrived", sb.expected_moves.size());
        if (sb.n_bad == 0 && sb.expected_moves.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/pdmpl_pkg.sv
sv/pdmpl_ctrl.sv
sv/pdmpl_dp.sv
sv/pd_motor_position_loop_core.sv
sv/pdmpl_checker.sv
dv/testbench.sv
